// ===== design/ppa_pkg.sv =====
// ----------------------------------------------------------------------------
// ppa_pkg
// Shared types and constants for the page pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ppa_pkg;

  // Default number of pages in the pool.
  localparam int POOL_PAGES_DEF = 4096;

  // Field widths.
  localparam int PAGE_W   = 12;
  localparam int MAXP_W   = 13;
  localparam int STATUS_W = 2;

  // Reset value of the page limit register.
  localparam logic [MAXP_W-1:0] MAXP_RESET = 13'd4096;

  // Request commands.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_CAPACITY  = 2'd1,
    ST_RANGE     = 2'd2,
    ST_DBL_FREE  = 2'd3
  } status_t;

endpackage

`default_nettype wire

// ===== design/ppa_ram.sv =====
// ----------------------------------------------------------------------------
// ppa_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ppa_ram
  import ppa_pkg::*;
#(
  parameter int WIDTH = PAGE_W,
  parameter int DEPTH = POOL_PAGES_DEF
) (
  input  wire logic                     clk,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic                     we,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle: an optional write, and a registered read of the entry as it was before that write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== design/page_pool_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// page_pool_allocator_unit
// Page allocator with a LIFO free stack and a freed flag per page, both kept
// in single-port synchronous RAMs.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                         Transfer
//  -------   -----------------------------   ---------------------------------
//  request   start, busy, command,           start high while busy is low
//            page_index
//  result    done, page_out, status          done high for one cycle
//  config    cfg_valid, cfg_ready, cfg_data  cfg_valid and cfg_ready high
//
// A stack pop or an accepted free reads the RAM entry, then writes back the
// flag or stack entry. Creating a new page, or rejecting a request for
// capacity or range, is answered from idle. The result appears in the cycle
// after the request finishes, while the next request may already be taken.
// After reset the flag RAM is cleared one entry a cycle, all POOL_PAGES
// entries, with busy high. The receiver cannot stall results; cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module page_pool_allocator_unit
  import ppa_pkg::*;
#(
  parameter int POOL_PAGES = POOL_PAGES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // Request channel.
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                command,
  input  wire logic [PAGE_W-1:0]   page_index,
  // Result channel.
  output logic                     done,
  output logic      [PAGE_W-1:0]   page_out,
  output logic      [STATUS_W-1:0] status,
  // Configuration channel.
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [MAXP_W-1:0]   cfg_data
);

  localparam int ADDR_W  = $clog2(POOL_PAGES);
  localparam int DEPTH_W = $clog2(POOL_PAGES + 1);
  localparam int CMP_W   = (DEPTH_W > MAXP_W) ? DEPTH_W : MAXP_W;

  localparam logic [CMP_W-1:0]  POOL_CMP  = CMP_W'(POOL_PAGES);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(POOL_PAGES - 1);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_POP   = 4'b0100,
    S_PUSH  = 4'b1000
  } state_t;

  state_t              state;
  logic [ADDR_W-1:0]   clr_addr;
  logic [DEPTH_W-1:0]  free_depth;
  logic [DEPTH_W-1:0]  created_count;
  logic [MAXP_W-1:0]   max_pages;
  logic [PAGE_W-1:0]   req_idx;

  logic [ADDR_W-1:0]   stk_addr;
  logic                stk_we;
  logic [PAGE_W-1:0]   stk_rdata;
  logic [ADDR_W-1:0]   flg_addr;
  logic                flg_we;
  logic                flg_wdata;
  logic                flg_rdata;

  logic                accept;
  logic                stack_empty;
  logic                at_limit;
  logic                idx_bad;
  logic                push_ok;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Request decode against the current counters.
  assign stack_empty = (free_depth == '0);
  assign at_limit    = (CMP_W'(created_count) >= CMP_W'(max_pages)) ||
                       (CMP_W'(created_count) >= POOL_CMP);
  assign idx_bad     = (CMP_W'(page_index) >= CMP_W'(created_count)) ||
                       (CMP_W'(page_index) >= POOL_CMP);
  assign push_ok     = !flg_rdata && (CMP_W'(free_depth) < POOL_CMP);

  // Free stack port: pop reads below the top, push writes at the top.
  always_comb begin
    if (state == S_PUSH) begin
      stk_addr = ADDR_W'(free_depth);
    end else begin
      stk_addr = ADDR_W'(free_depth - 1'b1);
    end
    stk_we = (state == S_PUSH) && push_ok;
  end

  // Freed flag port: clearing pass, lookup on a free, write-back after a free or a pop.
  always_comb begin
    case (state)
      S_CLEAR: begin
        flg_addr  = clr_addr;
        flg_we    = 1'b1;
        flg_wdata = 1'b0;
      end
      S_POP: begin
        flg_addr  = ADDR_W'(stk_rdata);
        flg_we    = 1'b1;
        flg_wdata = 1'b0;
      end
      S_PUSH: begin
        flg_addr  = ADDR_W'(req_idx);
        flg_we    = push_ok;
        flg_wdata = 1'b1;
      end
      default: begin
        flg_addr  = ADDR_W'(page_index);
        flg_we    = 1'b0;
        flg_wdata = 1'b0;
      end
    endcase
  end

  ppa_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (POOL_PAGES)
  ) u_stack (
    .clk   (clk),
    .addr  (stk_addr),
    .we    (stk_we),
    .wdata (req_idx),
    .rdata (stk_rdata)
  );

  ppa_ram #(
    .WIDTH (1),
    .DEPTH (POOL_PAGES)
  ) u_flags (
    .clk   (clk),
    .addr  (flg_addr),
    .we    (flg_we),
    .wdata (flg_wdata),
    .rdata (flg_rdata)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_pages <= MAXP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_pages <= cfg_data;
    end
  end

  // Sequencer, counters and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      free_depth    <= '0;
      created_count <= '0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            req_idx <= page_index;
            if (command == CMD_ALLOC) begin
              if (!stack_empty) begin
                free_depth <= free_depth - 1'b1;
                state      <= S_POP;
              end else if (at_limit) begin
                done     <= 1'b1;
                page_out <= '0;
                status   <= ST_CAPACITY;
              end else begin
                created_count <= created_count + 1'b1;
                done          <= 1'b1;
                page_out      <= PAGE_W'(created_count);
                status        <= ST_OK;
              end
            end else begin
              if (idx_bad) begin
                done     <= 1'b1;
                page_out <= '0;
                status   <= ST_RANGE;
              end else begin
                state <= S_PUSH;
              end
            end
          end
        end
        S_POP: begin
          done     <= 1'b1;
          page_out <= stk_rdata;
          status   <= ST_OK;
          state    <= S_IDLE;
        end
        S_PUSH: begin
          done     <= 1'b1;
          page_out <= '0;
          if (flg_rdata) begin
            status <= ST_DBL_FREE;
          end else begin
            status <= ST_OK;
            if (push_ok) begin
              free_depth <= free_depth + 1'b1;
            end
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
